FILE: rtl/core/matd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matd_pkg
// Shared types and constants of the motion adaptive temporal denoiser.
// ----------------------------------------------------------------------------
package matd_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_SLOPE  = 2'd2,
    CFG_OFFSET = 2'd3
  } cfg_index_t;

  localparam int PIX_W      = 8;
  localparam int MIN_HEIGHT = 4;
  // rows 0..EDGE_ROWS-1 and the last EDGE_ROWS rows pass through
  localparam int EDGE_ROWS  = 2;
  // first input row that releases a filtered row (two rows above it)
  localparam int FILT_START = 4;

  // alpha limits in Q8.8: 0.1 rounded, and 1.0
  localparam int ALPHA_FLOOR = 26;
  localparam int ALPHA_ONE   = 256;
  localparam int ROUND_HALF  = 128;

  // current pixel, previous frame pixel and the vertical neighbours
  typedef struct packed {
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] prev;
    logic [PIX_W-1:0] b2;
    logic [PIX_W-1:0] b1;
    logic [PIX_W-1:0] a1;
    logic [PIX_W-1:0] a2;
  } taps_t;

endpackage
`default_nettype wire

FILE: rtl/core/matd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matd_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module matd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read returns the old contents on a same-address write
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/matd_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matd_blend
// Two-stage blend datapath: motion weight, then blend, range clamp and round.
// ----------------------------------------------------------------------------
module matd_blend (
  input  wire logic                   clk,
  input  wire logic                   load_c,
  input  wire logic                   load_d,
  input  wire logic signed [15:0]     slope,
  input  wire logic signed [15:0]     offset,
  input  wire matd_pkg::taps_t        taps,
  output      logic [matd_pkg::PIX_W-1:0] pix
);

  localparam int PW = matd_pkg::PIX_W;

  logic signed [PW:0]     diff;
  logic [PW-1:0]          abs_diff;
  logic signed [PW+16:0]  weight_prod;
  logic signed [PW+17:0]  weight_calc;
  logic [PW-1:0]          lo_calc;
  logic [PW-1:0]          hi_calc;

  logic signed [PW+17:0]  c_weight;
  logic signed [PW:0]     c_diff;
  logic [PW-1:0]          c_prev;
  logic [PW-1:0]          c_lo;
  logic [PW-1:0]          c_hi;

  logic [PW:0]            alpha;
  logic signed [2*PW+2:0] blend_prod;
  logic signed [2*PW+3:0] blend_val;
  logic signed [2*PW+3:0] lo_val;
  logic signed [2*PW+3:0] hi_val;
  logic signed [2*PW+3:0] clamp_val;
  logic signed [2*PW+3:0] round_val;

  function automatic logic [PW-1:0] min2(input logic [PW-1:0] a, input logic [PW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PW-1:0] max2(input logic [PW-1:0] a, input logic [PW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // stage C: temporal difference, motion weight before clamping and neighbour range
  always_comb begin
    diff        = $signed({1'b0, taps.cur}) - $signed({1'b0, taps.prev});
    abs_diff    = diff[PW] ? PW'(-diff) : PW'(diff);
    weight_prod = $signed({1'b0, abs_diff}) * slope;
    weight_calc = (PW+18)'(weight_prod) + (PW+18)'(offset);
    lo_calc     = min2(min2(min2(taps.a1, taps.b1), taps.cur), min2(taps.a2, taps.b2));
    hi_calc     = max2(max2(max2(taps.a1, taps.b1), taps.cur), max2(taps.a2, taps.b2));
  end

  always_ff @(posedge clk) begin
    if (load_c) begin
      c_weight <= weight_calc;
      c_diff   <= diff;
      c_prev   <= taps.prev;
      c_lo     <= lo_calc;
      c_hi     <= hi_calc;
    end
  end

  // stage D: clamp alpha, blend prev toward cur, clamp to the neighbour range
  always_comb begin
    if (c_weight < (PW+18)'(matd_pkg::ALPHA_FLOOR)) begin
      alpha = (PW+1)'(matd_pkg::ALPHA_FLOOR);
    end else if (c_weight > (PW+18)'(matd_pkg::ALPHA_ONE)) begin
      alpha = (PW+1)'(matd_pkg::ALPHA_ONE);
    end else begin
      alpha = c_weight[PW:0];
    end
    blend_prod = $signed({1'b0, alpha}) * c_diff;
    blend_val  = $signed({4'b0, c_prev, 8'b0}) + (2*PW+4)'(blend_prod);
    lo_val     = $signed({4'b0, c_lo, 8'b0});
    hi_val     = $signed({4'b0, c_hi, 8'b0});
    clamp_val  = blend_val;
    if (clamp_val < lo_val) begin
      clamp_val = lo_val;
    end
    if (clamp_val > hi_val) begin
      clamp_val = hi_val;
    end
    round_val = clamp_val + (2*PW+4)'(matd_pkg::ROUND_HALF);
  end

  always_ff @(posedge clk) begin
    if (load_d) begin
      pix <= round_val[2*PW-1:PW];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/motion_adaptive_temporal_denoise_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motion_adaptive_temporal_denoise_top
// Recursive temporal denoiser for one 8-bit plane with motion adaptive blend.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per cycle while in_ready is high. Rows
// 2..H-3 are blended from the previous filtered frame toward the current pixel
// and released two rows late; rows 0, 1, H-2 and H-1 pass through. An item in
// the last two rows can cause two results, which share the single output port,
// so it holds stage D until both are taken. The row store is one word per
// column holding four rows, read and written back once per item; the
// previous-frame store is read once per item and written once per result.
// An input passes through registered stages B, C and D. Size writes restart the
// frame and treat the next frame as having no history.
module motion_adaptive_temporal_denoise_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [7:0]  pixel_in,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [7:0]  pixel_out,
  output      logic [9:0]  out_row,
  output      logic [9:0]  out_col,
  output      logic        last
);

  localparam int PW    = matd_pkg::PIX_W;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SWW   = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int SHW   = ($clog2(MAX_HEIGHT + 1) > 11) ? $clog2(MAX_HEIGHT + 1) : 11;
  localparam int LW    = 4 * PW;

  // configuration
  logic [10:0]        frame_width;
  logic [10:0]        frame_height;
  logic signed [15:0] alpha_slope;
  logic signed [15:0] alpha_offset;
  logic               primed;
  logic [CW-1:0]      col_count;
  logic [RW-1:0]      row_count;
  logic [AW-1:0]      row_base;

  logic [SWW-1:0] width_ext;
  logic [SWW-1:0] width_eff;
  logic [SHW-1:0] height_ext;
  logic [SHW-1:0] height_eff;
  logic           last_col;
  logic           last_row;
  logic           in_filt;
  logic           in_pass;
  logic           accept;

  // stage B: memory data returned
  logic                  b_valid;
  logic [PW-1:0]         b_pix;
  logic [RW-1:0]         b_row;
  logic [CW-1:0]         b_col;
  logic                  b_filt;
  logic                  b_pass;
  logic                  b_primed;
  logic [AW-1:0]         b_faddr;
  logic [AW-1:0]         b_paddr;
  logic                  b_fwd;
  logic [3:0][PW-1:0]    b_fwd_word;
  logic [3:0][PW-1:0]    row_word;
  logic [3:0][PW-1:0]    row_word_next;
  logic [LW-1:0]         row_rdata;
  logic [PW-1:0]         prev_rdata;
  logic [1:0]            lane;
  matd_pkg::taps_t       taps;
  logic                  b_ready;
  logic                  row_we;

  // stage C: motion weight
  logic           c_valid;
  logic [PW-1:0]  c_pix;
  logic [RW-1:0]  c_row;
  logic [CW-1:0]  c_col;
  logic           c_filt;
  logic           c_pass;
  logic [AW-1:0]  c_faddr;
  logic [AW-1:0]  c_paddr;
  logic           c_ready;

  // stage D: results waiting for the output
  logic           d_valid;
  logic [PW-1:0]  d_pix;
  logic [PW-1:0]  d_fpix;
  logic [RW-1:0]  d_row;
  logic [CW-1:0]  d_col;
  logic           d_filt;
  logic           d_pass;
  logic           d_phase;
  logic [AW-1:0]  d_faddr;
  logic [AW-1:0]  d_paddr;
  logic           d_ready;
  logic           d_adv;
  logic           emit_filt;
  logic           emit_final;
  logic           out_fire;

  // effective frame size
  always_comb begin
    width_ext  = SWW'(frame_width);
    height_ext = SHW'(frame_height);
    if (width_ext == '0) begin
      width_eff = SWW'(1);
    end else if (width_ext > SWW'(MAX_WIDTH)) begin
      width_eff = SWW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    if (height_ext < SHW'(matd_pkg::MIN_HEIGHT)) begin
      height_eff = SHW'(matd_pkg::MIN_HEIGHT);
    end else if (height_ext > SHW'(MAX_HEIGHT)) begin
      height_eff = SHW'(MAX_HEIGHT);
    end else begin
      height_eff = height_ext;
    end
    last_col = (SWW'(col_count) + SWW'(1)) == width_eff;
    last_row = (SHW'(row_count) + SHW'(1)) == height_eff;
    in_filt  = row_count >= RW'(matd_pkg::FILT_START);
    in_pass  = (row_count < RW'(matd_pkg::EDGE_ROWS)) ||
               ((SHW'(row_count) + SHW'(matd_pkg::EDGE_ROWS)) >= height_eff);
  end

  assign accept   = in_valid & in_ready;
  assign in_ready = b_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 11'd1024;
      frame_height <= 11'd1024;
      alpha_slope  <= 16'sd92;
      alpha_offset <= -16'sd113;
      primed       <= 1'b0;
      col_count    <= '0;
      row_count    <= '0;
      row_base     <= '0;
    end else if (cfg_we) begin
      unique case (matd_pkg::cfg_index_t'(cfg_index))
        matd_pkg::CFG_WIDTH: begin
          frame_width <= cfg_data[10:0];
          primed      <= 1'b0;
          col_count   <= '0;
          row_count   <= '0;
          row_base    <= '0;
        end
        matd_pkg::CFG_HEIGHT: begin
          frame_height <= cfg_data[10:0];
          primed       <= 1'b0;
          col_count    <= '0;
          row_count    <= '0;
          row_base     <= '0;
        end
        matd_pkg::CFG_SLOPE:  alpha_slope  <= cfg_data;
        matd_pkg::CFG_OFFSET: alpha_offset <= cfg_data;
        default: ;
      endcase
    end else if (accept) begin
      if (last_col) begin
        col_count <= '0;
        if (last_row) begin
          row_count <= '0;
          row_base  <= '0;
          primed    <= 1'b1;
        end else begin
          row_count <= row_count + RW'(1);
          row_base  <= row_base + AW'(MAX_WIDTH);
        end
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // row store: one word per column, four rows side by side
  matd_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (b_col),
    .wdata (row_word_next),
    .re    (accept),
    .raddr (col_count),
    .rdata (row_rdata)
  );

  // previous filtered frame
  matd_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_prev_ram (
    .clk   (clk),
    .we    (out_fire),
    .waddr (emit_filt ? d_faddr : d_paddr),
    .wdata (pixel_out),
    .re    (accept),
    .raddr (row_base - AW'(2 * MAX_WIDTH) + AW'(col_count)),
    .rdata (prev_rdata)
  );

  assign b_ready = !b_valid || c_ready;
  assign row_we  = b_valid && c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_pix      <= pixel_in;
      b_row      <= row_count;
      b_col      <= col_count;
      b_filt     <= in_filt;
      b_pass     <= in_pass;
      b_primed   <= primed;
      b_faddr    <= row_base - AW'(2 * MAX_WIDTH) + AW'(col_count);
      b_paddr    <= row_base + AW'(col_count);
      // the word being written back now is newer than the one read
      b_fwd      <= row_we && (b_col == col_count);
      b_fwd_word <= row_word_next;
    end
  end

  always_comb begin
    row_word      = b_fwd ? b_fwd_word : row_rdata;
    lane          = b_row[1:0];
    row_word_next = row_word;
    row_word_next[lane] = b_pix;
    taps.b2  = row_word[lane];
    taps.b1  = row_word[lane + 2'd1];
    taps.cur = row_word[lane + 2'd2];
    taps.a1  = row_word[lane + 2'd3];
    taps.a2  = b_pix;
    // no history yet: take the current pixel as previous
    taps.prev = b_primed ? prev_rdata : row_word[lane + 2'd2];
  end

  matd_blend u_blend (
    .clk    (clk),
    .load_c (c_ready),
    .load_d (d_ready),
    .slope  (alpha_slope),
    .offset (alpha_offset),
    .taps   (taps),
    .pix    (d_fpix)
  );

  assign c_ready = !c_valid || d_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready) begin
      c_pix   <= b_pix;
      c_row   <= b_row;
      c_col   <= b_col;
      c_filt  <= b_filt;
      c_pass  <= b_pass;
      c_faddr <= b_faddr;
      c_paddr <= b_paddr;
    end
  end

  // output: filtered result first, pass-through second
  always_comb begin
    emit_filt  = d_filt && !d_phase;
    emit_final = !(emit_filt && d_pass);
    out_valid  = d_valid && (emit_filt || d_pass);
    out_fire   = out_valid && out_ready;
    d_adv      = d_valid && (!(emit_filt || d_pass) || (out_ready && emit_final));
    d_ready    = !d_valid || d_adv;
    pixel_out  = emit_filt ? d_fpix : d_pix;
    out_row    = emit_filt ? 10'(d_row - RW'(matd_pkg::EDGE_ROWS)) : 10'(d_row);
    out_col    = 10'(d_col);
    last       = emit_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      d_phase <= 1'b0;
    end else if (d_ready) begin
      d_valid <= c_valid;
      d_phase <= 1'b0;
    end else if (out_fire) begin
      // first of two results taken: hold for the pass-through one
      d_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) begin
      d_pix   <= c_pix;
      d_row   <= c_row;
      d_col   <= c_col;
      d_filt  <= c_filt;
      d_pass  <= c_pass;
      d_faddr <= c_faddr;
      d_paddr <= c_paddr;
    end
  end

endmodule
`default_nettype wire

FILE: bench/motion_adaptive_temporal_denoise_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_adaptive_temporal_denoise_top_tb
// Self-checking bench for the motion adaptive temporal denoiser. Pixel frames
// of many sizes are streamed through the valid/ready ports under random source
// gaps and sink back-pressure. Every output pixel, with its row, column and
// last flag, is compared with an in-bench model of the recursive blend, the
// vertical neighbour clamp, the previous-frame store and the row timing.
// ----------------------------------------------------------------------------
module motion_adaptive_temporal_denoise_top_tb;
  import matd_pkg::*;

  localparam int MAX_W          = 1024;
  localparam int MAX_H          = 1024;
  localparam int ALPHA_MIN_Q8   = 26;
  localparam int ALPHA_UNITY_Q8 = 256;
  localparam int RANDOM_ITEMS   = 1150;
  localparam int QUIET_ITEMS    = 120;
  localparam int SETTLE_CYCLES  = 12;
  localparam int MAX_REPORTS    = 40;
  localparam int WATCHDOG_NS    = 1500000;

  typedef struct packed {
    bit [7:0] pix;
    bit [9:0] row;
    bit [9:0] col;
    bit       last;
  } denoise_result_t;

  typedef enum {PAT_UNIFORM, PAT_NOISY, PAT_EXTREME} pixel_pattern_t;

  class denoise_checker;
    bit [10:0]       width_reg;
    bit [10:0]       height_reg;
    shortint         slope_q8;
    shortint         offset_q8;
    bit              primed;
    int unsigned     col_pos;
    int unsigned     row_pos;
    bit [7:0]        line_buf [4][MAX_W];
    bit [7:0]        filtered_frame [int unsigned];
    denoise_result_t expected_results [$];
    int              errors;

    function new();
      width_reg  = 11'd1024;
      height_reg = 11'd1024;
      slope_q8   = 16'sd92;
      offset_q8  = -16'sd113;
      primed     = 1'b0;
      col_pos    = 0;
      row_pos    = 0;
      errors     = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < MIN_HEIGHT) return MIN_HEIGHT;
      if (height_reg > MAX_H) return MAX_H;
      return height_reg;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void write_reg(cfg_index_t idx, bit [15:0] val);
      case (idx)
        CFG_WIDTH:  width_reg  = val[10:0];
        CFG_HEIGHT: height_reg = val[10:0];
        CFG_SLOPE:  slope_q8   = shortint'(val);
        CFG_OFFSET: offset_q8  = shortint'(val);
      endcase
      // a new size restarts the frame with no history
      if (idx == CFG_WIDTH || idx == CFG_HEIGHT) begin
        primed  = 1'b0;
        col_pos = 0;
        row_pos = 0;
      end
    endfunction

    function bit [7:0] temporal_blend(int cur, int prev, int b2, int b1, int a1, int a2);
      int diff;
      int mag;
      int t;
      int alpha;
      int v;
      int hi;
      int lo;
      int nb [4];
      diff  = cur - prev;
      mag   = (diff < 0) ? -diff : diff;
      t     = mag * int'(slope_q8) + int'(offset_q8);
      alpha = (t < ALPHA_MIN_Q8) ? ALPHA_MIN_Q8 : ((t > ALPHA_UNITY_Q8) ? ALPHA_UNITY_Q8 : t);
      v     = prev * 256 + alpha * diff;
      nb    = '{b2, b1, a1, a2};
      hi    = cur;
      lo    = cur;
      foreach (nb[i]) begin
        if (nb[i] > hi) hi = nb[i];
        if (nb[i] < lo) lo = nb[i];
      end
      if (v < lo * 256) v = lo * 256;
      if (v > hi * 256) v = hi * 256;
      return 8'((v + 128) >> 8);
    endfunction

    // every output also becomes the previous frame for the next pass
    function denoise_result_t keep_output(bit [7:0] pix, int unsigned row, int unsigned col);
      denoise_result_t res;
      filtered_frame[row * MAX_W + col] = pix;
      res.pix  = pix;
      res.row  = 10'(row);
      res.col  = 10'(col);
      res.last = 1'b0;
      return res;
    endfunction

    function void take_pixel(bit [7:0] p);
      int unsigned     w;
      int unsigned     h;
      int unsigned     r;
      int unsigned     c;
      int unsigned     j;
      int unsigned     prev_pix;
      denoise_result_t res [2];
      int              n;
      w = eff_width();
      h = eff_height();
      n = 0;
      if (row_pos >= h || col_pos >= w) begin
        row_pos = 0;
        col_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      if (r >= 4) begin
        j = r - 2;
        prev_pix = primed ? filtered_frame[j * MAX_W + c] : line_buf[j % 4][c];
        res[n] = keep_output(temporal_blend(line_buf[j % 4][c], prev_pix, line_buf[r % 4][c],
                                            line_buf[(r - 3) % 4][c], line_buf[(r - 1) % 4][c],
                                            p), j, c);
        n++;
      end
      line_buf[r % 4][c] = p;
      if (r < 2 || r >= h - 2) begin
        res[n] = keep_output(p, r, c);
        n++;
      end
      if (n > 0) res[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_results.push_back(res[i]);
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) begin
          row_pos = 0;
          primed  = 1'b1;
        end
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t MISMATCH %s", $time, msg);
    endtask

    task check_result(logic [7:0] pix, logic [9:0] row, logic [9:0] col, logic lst);
      denoise_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result pix %0d row %0d col %0d", pix, row, col));
        return;
      end
      want = expected_results.pop_front();
      if (pix !== want.pix)
        report_mismatch($sformatf("(%0d,%0d) pixel_out %0d, want %0d", want.row, want.col,
                                  pix, want.pix));
      if (row !== want.row)
        report_mismatch($sformatf("out_row %0d, want %0d", row, want.row));
      if (col !== want.col)
        report_mismatch($sformatf("out_col %0d, want %0d", col, want.col));
      if (lst !== want.last)
        report_mismatch($sformatf("(%0d,%0d) last %0b, want %0b", want.row, want.col,
                                  lst, want.last));
    endtask
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  cfg_index_t  cfg_index = CFG_WIDTH;
  logic [15:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  pixel_in  = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  pixel_out;
  logic [9:0]  out_row;
  logic [9:0]  out_col;
  logic        last;

  denoise_checker chk = new();

  bit             quiet_tail = 1'b0;
  bit             idle_in    = 1'b0;
  bit             stall_out  = 1'b0;
  pixel_pattern_t pattern    = PAT_UNIFORM;
  int unsigned    noise_amp  = 0;
  int unsigned    scene_pos  = 0;
  int unsigned    items_sent = 0;
  bit [7:0]       scene [64];

  motion_adaptive_temporal_denoise_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .pixel_in (pixel_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_out(pixel_out),
    .out_row  (out_row),
    .out_col  (out_col),
    .last     (last)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) chk.check_result(pixel_out, out_row, out_col, last);
  end

  initial begin : sink_pacing
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      if (quiet_tail || !stall_out) begin
        @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 24)) @(posedge clk);
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  function automatic bit [7:0] make_pixel(int unsigned pos);
    int v;
    case (pattern)
      PAT_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PAT_NOISY: begin
        v = int'(scene[pos % 64]) + int'($urandom_range(0, 2 * noise_amp)) - int'(noise_amp);
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
      end
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic write_reg(cfg_index_t idx, bit [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    chk.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic push_pixel(bit [7:0] p);
    if (idle_in && !quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= p;
    do @(posedge clk); while (!in_ready);
    chk.take_pixel(p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk.pending() != 0);
    // interior rows give no output, so the block may still be busy
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic stream_pixels(int unsigned n, int unsigned frame_px);
    for (int unsigned k = 0; k < n; k++) begin
      if (!quiet_tail && $urandom_range(0, 59) == 0) begin
        // hold the source until every pending result is out
        in_valid <= 1'b0;
        do @(posedge clk); while (chk.pending() != 0);
      end
      push_pixel(make_pixel(scene_pos % frame_px));
      scene_pos++;
      items_sent++;
    end
  endtask

  initial begin : watchdog
    #WATCHDOG_NS;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    static bit [7:0]  first_frame [10] = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h11,
                                           8'hC8, 8'h80, 8'h81, 8'hFF, 8'hFF};
    static bit [7:0]  second_frame [10] = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h11,
                                            8'hC9, 8'h01, 8'hFE, 8'h00, 8'hFF};
    static bit [15:0] corner_q8 [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
    int unsigned size_w;
    int unsigned size_h;
    int unsigned frame_px;
    int          gain;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset sizes: the first pixels pass straight through row 0
    push_pixel(8'h00);
    push_pixel(8'hFF);
    push_pixel(8'h5A);
    drain();

    // tiny frame, upper data bits must fall away: two wide, five high
    write_reg(CFG_WIDTH, 16'hF802);
    write_reg(CFG_HEIGHT, 16'h0005);
    foreach (first_frame[i]) push_pixel(first_frame[i]);
    drain();
    // second frame blends against the first with alpha pinned at its limits
    write_reg(CFG_SLOPE, 16'h7FFF);
    write_reg(CFG_OFFSET, 16'h8000);
    foreach (second_frame[i]) push_pixel(second_frame[i]);
    drain();

    // one pixel per row down a very tall plane
    idle_in   = 1'b1;
    stall_out = 1'b1;
    pattern   = PAT_NOISY;
    noise_amp = 6;
    foreach (scene[i]) scene[i] = 8'($urandom);
    write_reg(CFG_WIDTH, 16'h0000);
    write_reg(CFG_HEIGHT, 16'hFFFF);
    write_reg(CFG_SLOPE, 16'd92);
    write_reg(CFG_OFFSET, 16'hFF8F);
    scene_pos = 0;
    stream_pixels(520, chk.eff_width() * chk.eff_height());
    drain();

    // widest row, shortest plane
    pattern = PAT_UNIFORM;
    write_reg(CFG_WIDTH, 16'hFFFF);
    write_reg(CFG_HEIGHT, 16'h0000);
    scene_pos = 0;
    stream_pixels(24, chk.eff_width() * chk.eff_height());
    drain();

    while (items_sent < RANDOM_ITEMS) begin
      quiet_tail = (items_sent >= RANDOM_ITEMS - QUIET_ITEMS);
      idle_in    = ($urandom_range(0, 2) != 0);
      stall_out  = ($urandom_range(0, 2) != 0);
      if (chk.eff_width() * chk.eff_height() > 80 || $urandom_range(0, 3) != 0) begin
        size_w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        size_h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 8);
        write_reg(CFG_WIDTH, {5'($urandom), 11'(size_w)});
        write_reg(CFG_HEIGHT, {5'($urandom), 11'(size_h)});
        scene_pos = 0;
      end
      case ($urandom_range(0, 3))
        1: begin
          gain = $urandom_range(8, 300);
          write_reg(CFG_SLOPE, 16'(gain));
          write_reg(CFG_OFFSET, 16'(ALPHA_MIN_Q8 - (3 * gain) / 2));
        end
        2: begin
          write_reg(CFG_SLOPE, 16'($urandom));
          write_reg(CFG_OFFSET, 16'($urandom));
        end
        3: begin
          write_reg(CFG_SLOPE, corner_q8[$urandom_range(0, 3)]);
          write_reg(CFG_OFFSET, corner_q8[$urandom_range(0, 3)]);
        end
        default: begin
          // keep the blend settings and carry on mid-frame
        end
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: pattern = PAT_UNIFORM;
        3:       pattern = PAT_EXTREME;
        default: pattern = PAT_NOISY;
      endcase
      noise_amp = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(0, 12);
      foreach (scene[i]) scene[i] = 8'($urandom);
      frame_px = chk.eff_width() * chk.eff_height();
      stream_pixels($urandom_range(1, 2) * frame_px + $urandom_range(0, frame_px - 1),
                    frame_px);
      drain();
    end

    quiet_tail = 1'b1;
    drain();
    if (chk.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
